>>> rtl/core/vspi_pkg.sv
// Shared types, register codes and constants of the vertical speed PI controller.
package vspi_pkg;

    localparam int unsigned QW     = 32;
    localparam int unsigned FRAC   = 16;
    localparam int unsigned SPW    = 17;
    localparam int unsigned IDXW   = 3;
    localparam int unsigned PRODW  = 2 * QW - FRAC + 1;

    localparam logic [SPW-1:0] SP_RESET = 17'd1311;

    typedef enum logic [IDXW-1:0] {
        REG_GAIN_INTEGRAL   = 3'd0,
        REG_GAIN_VSPEED     = 3'd1,
        REG_GAIN_PITCH_RATE = 3'd2,
        REG_GAIN_ACCEL      = 3'd3,
        REG_TRIM_OFFSET     = 3'd4,
        REG_SAMPLE_PERIOD   = 3'd5
    } t_reg_idx;

    typedef logic [QW-1:0]    t_q;
    typedef logic [PRODW-1:0] t_rprod;

    typedef struct packed {
        t_q             gain_integral;
        t_q             gain_vspeed;
        t_q             gain_pitch_rate;
        t_q             gain_accel;
        t_q             trim_offset;
        logic [SPW-1:0] sample_period;
    } t_cfg;

    typedef struct packed {
        t_q vspeed_meas;
        t_q vspeed_cmd;
        t_q pitch_rate;
        t_q vert_accel;
    } t_sample;

    typedef struct packed {
        t_rprod p_int;
        t_rprod p_vs;
        t_rprod p_pr;
        t_rprod p_ac;
    } t_prods;

endpackage

>>> rtl/core/vspi_cfg.sv
// Configuration register file of the vertical speed PI controller.
module vspi_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vspi_pkg::IDXW-1:0]   i_cfg_idx,
    input  logic [vspi_pkg::QW-1:0]     i_cfg_data,
    output vspi_pkg::t_cfg              o_cfg
);

    vspi_pkg::t_cfg r_cfg;
    vspi_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (vspi_pkg::t_reg_idx'(i_cfg_idx))
                vspi_pkg::REG_GAIN_INTEGRAL:   n_cfg.gain_integral   = i_cfg_data;
                vspi_pkg::REG_GAIN_VSPEED:     n_cfg.gain_vspeed     = i_cfg_data;
                vspi_pkg::REG_GAIN_PITCH_RATE: n_cfg.gain_pitch_rate = i_cfg_data;
                vspi_pkg::REG_GAIN_ACCEL:      n_cfg.gain_accel      = i_cfg_data;
                vspi_pkg::REG_TRIM_OFFSET:     n_cfg.trim_offset     = i_cfg_data;
                vspi_pkg::REG_SAMPLE_PERIOD:
                    n_cfg.sample_period = i_cfg_data[vspi_pkg::SPW-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_integral   <= '0;
            r_cfg.gain_vspeed     <= '0;
            r_cfg.gain_pitch_rate <= '0;
            r_cfg.gain_accel      <= '0;
            r_cfg.trim_offset     <= '0;
            r_cfg.sample_period   <= vspi_pkg::SP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/vspi_prod.sv
// Product stage: four rounded gain products and the saturating integrator update.
module vspi_prod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vspi_pkg::t_cfg      i_cfg,
    input  logic                i_load,
    input  vspi_pkg::t_sample   i_smp,
    output vspi_pkg::t_prods    o_prods
);

    localparam int unsigned EW  = vspi_pkg::QW + 1;
    localparam int unsigned EPW = EW + vspi_pkg::SPW + 1;
    localparam int unsigned ERW = EPW + 1 - vspi_pkg::FRAC;
    localparam int unsigned SW  = ERW + 1;

    logic [vspi_pkg::QW-1:0] r_sum;
    logic [vspi_pkg::QW-1:0] n_sum;
    vspi_pkg::t_prods        r_prods;
    vspi_pkg::t_prods        n_prods;

    logic signed [2*vspi_pkg::QW-1:0] m_int, m_vs, m_pr, m_ac;
    logic signed [EW-1:0]             err;
    logic signed [EPW-1:0]            m_err;
    logic signed [EPW:0]              err_bias;
    logic signed [ERW-1:0]            rnd_err;
    logic signed [SW-1:0]             sum_wide;

    function automatic vspi_pkg::t_rprod rnd_q(input logic signed [2*vspi_pkg::QW-1:0] p);
        logic signed [2*vspi_pkg::QW:0] t;
        t = $signed({p[2*vspi_pkg::QW-1], p}) + (2*vspi_pkg::QW+1)'(1 << (vspi_pkg::FRAC-1));
        return t[2*vspi_pkg::QW:vspi_pkg::FRAC];
    endfunction

    always_comb begin
        m_int = $signed(i_cfg.gain_integral)   * $signed(r_sum);
        m_vs  = $signed(i_cfg.gain_vspeed)     * $signed(i_smp.vspeed_meas);
        m_pr  = $signed(i_cfg.gain_pitch_rate) * $signed(i_smp.pitch_rate);
        m_ac  = $signed(i_cfg.gain_accel)      * $signed(i_smp.vert_accel);
        n_prods.p_int = rnd_q(m_int);
        n_prods.p_vs  = rnd_q(m_vs);
        n_prods.p_pr  = rnd_q(m_pr);
        n_prods.p_ac  = rnd_q(m_ac);

        err = $signed({i_smp.vspeed_cmd[vspi_pkg::QW-1], i_smp.vspeed_cmd})
            - $signed({i_smp.vspeed_meas[vspi_pkg::QW-1], i_smp.vspeed_meas});
        m_err = $signed({1'b0, i_cfg.sample_period}) * err;
        err_bias = $signed({m_err[EPW-1], m_err}) + (EPW+1)'(1 << (vspi_pkg::FRAC-1));
        rnd_err = err_bias[EPW:vspi_pkg::FRAC];
        sum_wide = $signed({rnd_err[ERW-1], rnd_err})
                 + $signed({{(SW-vspi_pkg::QW){r_sum[vspi_pkg::QW-1]}}, r_sum});
        if (sum_wide[SW-1:vspi_pkg::QW-1] == '0 || sum_wide[SW-1:vspi_pkg::QW-1] == '1) begin
            n_sum = sum_wide[vspi_pkg::QW-1:0];
        end else if (sum_wide[SW-1]) begin
            n_sum = {1'b1, {(vspi_pkg::QW-1){1'b0}}};
        end else begin
            n_sum = {1'b0, {(vspi_pkg::QW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_load) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prods <= n_prods;
        end
    end

    assign o_prods = r_prods;

    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_load |=> $stable(r_sum))
        else $error("integrator changed without a word advancing");

endmodule

>>> rtl/core/vspi_acc.sv
// Output stage: sum of rounded products and trim, saturation, result register.
module vspi_acc (
    input  logic                        i_clk,
    input  vspi_pkg::t_cfg              i_cfg,
    input  logic                        i_load,
    input  vspi_pkg::t_prods            i_prods,
    output logic [vspi_pkg::QW-1:0]     o_cmd
);

    localparam int unsigned AW = vspi_pkg::PRODW + 3;

    logic signed [AW-1:0]    acc;
    logic [vspi_pkg::QW-1:0] r_cmd;
    logic [vspi_pkg::QW-1:0] n_cmd;

    function automatic logic signed [AW-1:0] sx(input vspi_pkg::t_rprod p);
        return $signed({{(AW-vspi_pkg::PRODW){p[vspi_pkg::PRODW-1]}}, p});
    endfunction

    always_comb begin
        acc = sx(i_prods.p_int) + sx(i_prods.p_vs) + sx(i_prods.p_pr) + sx(i_prods.p_ac)
            + $signed({{(AW-vspi_pkg::QW){i_cfg.trim_offset[vspi_pkg::QW-1]}},
                       i_cfg.trim_offset});
        if (acc[AW-1:vspi_pkg::QW-1] == '0 || acc[AW-1:vspi_pkg::QW-1] == '1) begin
            n_cmd = acc[vspi_pkg::QW-1:0];
        end else if (acc[AW-1]) begin
            n_cmd = {1'b1, {(vspi_pkg::QW-1){1'b0}}};
        end else begin
            n_cmd = {1'b0, {(vspi_pkg::QW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd = r_cmd;

endmodule

>>> rtl/core/vertical_speed_pi_control_top.sv
// Top level of the vertical speed PI controller with state feedback.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  in       | i_in_valid / o_in_ready    | vspeed_meas, vspeed_cmd, pitch_rate, vert_accel
//  out      | o_out_valid / i_out_ready  | elevator_cmd
//  cfg      | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One word per cycle unless the output stalls; an accepted word passes the input
// register at the accepting edge, then the product register and the result register.
// The integrator loop (17x33 multiply, round, add, saturate) closes through the integrator register alone.
// Synchronous reset clears all stage valids and the integrator, gains and trim,
// and sets sample_period to 1311.
// A stalled output holds its word; each stage still takes a word while a later
// stage has room, so o_in_ready drops only when all three stages are full.
module vertical_speed_pi_control_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vspi_pkg::IDXW-1:0]   i_cfg_idx,
    input  logic [vspi_pkg::QW-1:0]     i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [vspi_pkg::QW-1:0]     i_vspeed_meas,
    input  logic [vspi_pkg::QW-1:0]     i_vspeed_cmd,
    input  logic [vspi_pkg::QW-1:0]     i_pitch_rate,
    input  logic [vspi_pkg::QW-1:0]     i_vert_accel,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [vspi_pkg::QW-1:0]     o_elevator_cmd
);

    vspi_pkg::t_cfg     cfg;
    vspi_pkg::t_sample  r_smp;
    vspi_pkg::t_prods   prods;

    logic r_iv, r_pv, r_ov;
    logic rdy_out, rdy_prod, in_acc, load_prod, load_out;

    assign rdy_out    = !r_ov || i_out_ready;
    assign rdy_prod   = !r_pv || rdy_out;
    assign o_in_ready = !r_iv || rdy_prod;
    assign in_acc     = i_in_valid && o_in_ready;
    assign load_prod  = r_iv && rdy_prod;
    assign load_out   = r_pv && rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_iv <= i_in_valid;
            end
            if (rdy_prod) begin
                r_pv <= r_iv;
            end
            if (rdy_out) begin
                r_ov <= r_pv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp.vspeed_meas <= i_vspeed_meas;
            r_smp.vspeed_cmd  <= i_vspeed_cmd;
            r_smp.pitch_rate  <= i_pitch_rate;
            r_smp.vert_accel  <= i_vert_accel;
        end
    end

    vspi_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    vspi_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_load  (load_prod),
        .i_smp   (r_smp),
        .o_prods (prods)
    );

    vspi_acc u_acc (
        .i_clk   (i_clk),
        .i_cfg   (cfg),
        .i_load  (load_out),
        .i_prods (prods),
        .o_cmd   (o_elevator_cmd)
    );

    assign o_out_valid = r_ov;

    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_iv && r_pv && r_ov))
        else $error("input stalled with a free stage");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_iv)
        else $error("accepted word lost from input register");

    a_out_from_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_pv))
        else $error("result appeared without a product word");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the vertical speed PI controller against a Q16.16 predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned GAP_MAX     = 6;
    localparam int unsigned LONG_HOLD   = 80;
    localparam int unsigned HOLD_AT_A   = 150;
    localparam int unsigned HOLD_AT_B   = 450;
    localparam int unsigned WDOG_LIMIT  = 2000;
    localparam int unsigned RAND_PHASES = 8;
    localparam int unsigned PHASE_WORDS = 85;
    localparam int unsigned DRAIN_WAIT  = 10;

    localparam logic [vspi_pkg::IDXW-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [vspi_pkg::IDXW-1:0] IDX_SPARE_HI = 3'd7;

    localparam vspi_pkg::t_q Q_MAX   = 32'h7fff_ffff;
    localparam vspi_pkg::t_q Q_MIN   = 32'h8000_0000;
    localparam longint       S32_MAX = 64'sd2147483647;
    localparam longint       S32_MIN = -S32_MAX - 64'sd1;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [vspi_pkg::IDXW-1:0]  cfg_idx = '0;
    vspi_pkg::t_q               cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    vspi_pkg::t_sample          in_word = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    vspi_pkg::t_q               elev_out;

    vspi_pkg::t_cfg             law_cfg;
    longint                     integ_sum;
    vspi_pkg::t_sample          pending_words[$];
    vspi_pkg::t_q               elev_expected[$];

    int unsigned    tx_gap = 0;
    int unsigned    rx_wait = 0;
    int unsigned    rx_count = 0;
    int unsigned    err_count = 0;
    int unsigned    idle_cycles = 0;
    bit             tx_burst = 1'b0;
    bit             rx_burst = 1'b0;

    vertical_speed_pi_control_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_vspeed_meas  (in_word.vspeed_meas),
        .i_vspeed_cmd   (in_word.vspeed_cmd),
        .i_pitch_rate   (in_word.pitch_rate),
        .i_vert_accel   (in_word.vert_accel),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_elevator_cmd (elev_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sx(vspi_pkg::t_q v);
        return longint'($signed(v));
    endfunction

    // round to nearest, ties toward +inf
    function automatic longint q_round(longint p);
        return (p + 64'sd32768) >>> vspi_pkg::FRAC;
    endfunction

    function automatic longint q_sat(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // command uses the integrator from before the word, then the integrator advances
    function automatic vspi_pkg::t_q elevator_law(vspi_pkg::t_sample s);
        longint acc;
        longint err;
        acc = q_round(sx(law_cfg.gain_integral) * integ_sum)
            + q_round(sx(law_cfg.gain_vspeed) * sx(s.vspeed_meas))
            + q_round(sx(law_cfg.gain_pitch_rate) * sx(s.pitch_rate))
            + q_round(sx(law_cfg.gain_accel) * sx(s.vert_accel))
            + sx(law_cfg.trim_offset);
        err = sx(s.vspeed_cmd) - sx(s.vspeed_meas);
        integ_sum = q_sat(integ_sum + q_round(longint'(law_cfg.sample_period) * err));
        return vspi_pkg::t_q'(q_sat(acc));
    endfunction

    function automatic void law_cfg_write(logic [vspi_pkg::IDXW-1:0] idx, vspi_pkg::t_q data);
        case (idx)
            vspi_pkg::REG_GAIN_INTEGRAL:   law_cfg.gain_integral   = data;
            vspi_pkg::REG_GAIN_VSPEED:     law_cfg.gain_vspeed     = data;
            vspi_pkg::REG_GAIN_PITCH_RATE: law_cfg.gain_pitch_rate = data;
            vspi_pkg::REG_GAIN_ACCEL:      law_cfg.gain_accel      = data;
            vspi_pkg::REG_TRIM_OFFSET:     law_cfg.trim_offset     = data;
            vspi_pkg::REG_SAMPLE_PERIOD:
                law_cfg.sample_period = data[vspi_pkg::SPW-1:0];
            default: ;
        endcase
    endfunction

    function automatic int unsigned draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic vspi_pkg::t_q span_q(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic vspi_pkg::t_q pick_extreme();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return 32'h0000_0001;
            4: return 32'hffff_ffff;
            default: return 32'h0000_8000;
        endcase
    endfunction

    function automatic vspi_pkg::t_q rand_q(bit wild);
        case ($urandom_range(0, 9))
            0: return pick_extreme();
            1, 2: return $urandom();
            default: return wild ? vspi_pkg::t_q'($urandom()) : span_q(32'h0040_0000);
        endcase
    endfunction

    function automatic vspi_pkg::t_q rand_gain(bit wild);
        case ($urandom_range(0, 7))
            0: return pick_extreme();
            1: return $urandom();
            default: return wild ? vspi_pkg::t_q'($urandom()) : span_q(32'h0004_0000);
        endcase
    endfunction

    // upper bits of a full random word are dropped by the 17-bit register
    function automatic vspi_pkg::t_q rand_period();
        case ($urandom_range(0, 3))
            0: return vspi_pkg::t_q'(vspi_pkg::SP_RESET);
            1: return $urandom_range(0, 65536);
            2: return $urandom_range(65537, 131071);
            default: return $urandom();
        endcase
    endfunction

    task automatic reg_write(logic [vspi_pkg::IDXW-1:0] idx, vspi_pkg::t_q data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        law_cfg_write(idx, data);
    endtask

    task automatic load_law(vspi_pkg::t_q gi, vspi_pkg::t_q gv, vspi_pkg::t_q gp,
                            vspi_pkg::t_q ga, vspi_pkg::t_q tr, vspi_pkg::t_q sp);
        reg_write(vspi_pkg::REG_GAIN_INTEGRAL, gi);
        reg_write(vspi_pkg::REG_GAIN_VSPEED, gv);
        reg_write(vspi_pkg::REG_GAIN_PITCH_RATE, gp);
        reg_write(vspi_pkg::REG_GAIN_ACCEL, ga);
        reg_write(vspi_pkg::REG_TRIM_OFFSET, tr);
        reg_write(vspi_pkg::REG_SAMPLE_PERIOD, sp);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || in_valid || elev_expected.size() != 0);
    endtask

    task automatic push_word(vspi_pkg::t_q vm, vspi_pkg::t_q vc, vspi_pkg::t_q pr,
                             vspi_pkg::t_q ac);
        pending_words.push_back('{vspeed_meas: vm, vspeed_cmd: vc, pitch_rate: pr,
                                  vert_accel: ac});
    endtask

    // input driver
    always @(posedge i_clk) begin
        bit drive;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            drive = in_valid;
            if (in_valid && in_ready) begin
                elev_expected.push_back(elevator_law(in_word));
                drive = 1'b0;
            end
            if (!drive) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                end else if (pending_words.size() != 0) begin
                    in_word <= pending_words.pop_front();
                    tx_gap  <= draw_gap(tx_burst);
                    drive = 1'b1;
                end
            end
            in_valid <= drive;
        end
    end

    // output monitor and checker
    always @(posedge i_clk) begin
        int unsigned w;
        vspi_pkg::t_q want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end else begin
            w = rx_wait;
            if (out_valid && out_ready) begin
                if (elev_expected.size() == 0) begin
                    $error("elevator_cmd: unexpected word, got %h", elev_out);
                    err_count++;
                end else begin
                    want = elev_expected.pop_front();
                    if (elev_out !== want) begin
                        $error("elevator_cmd: expected %h, got %h", want, elev_out);
                        err_count++;
                    end
                end
                rx_count <= rx_count + 1;
                // long hold lets the pipeline fill and back-pressure the input
                w = (rx_count + 1 == HOLD_AT_A || rx_count + 1 == HOLD_AT_B) ?
                    LONG_HOLD : draw_gap(rx_burst);
            end else if (w != 0) begin
                w = w - 1;
            end
            rx_wait   <= w;
            out_ready <= (w == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        bit wild;
        law_cfg = '0;
        law_cfg.sample_period = vspi_pkg::SP_RESET;
        integ_sum = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero gains, default period
        push_word('0, '0, '0, '0);
        push_word(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_word(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_word('0, 32'h0001_0000, '0, '0);
        wait_drained();

        // lsb gains, half period: half-lsb ties in the non-integral products and the integrator;
        // writes to unused indexes must be ignored
        reg_write(IDX_SPARE_LO, 32'hffff_ffff);
        reg_write(IDX_SPARE_HI, 32'hffff_ffff);
        load_law(32'd1, 32'd1, 32'd1, 32'd1, '0, 32'h0000_8000);
        push_word(32'h0000_8000, 32'h0000_8001, 32'h0000_8000, 32'hffff_8000);
        push_word(32'hffff_8000, 32'hffff_7fff, 32'hffff_8000, 32'h0000_8000);
        push_word(Q_MAX, Q_MIN, 32'd1, 32'hffff_ffff);
        wait_drained();

        // max gains and trim, max period above one second: saturation high and low
        load_law(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'h0001_ffff);
        push_word(Q_MIN, Q_MAX, Q_MIN, Q_MIN);
        push_word(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_word(Q_MAX, Q_MIN, '0, '0);
        push_word(Q_MAX, Q_MIN, '0, '0);
        push_word('0, '0, '0, '0);
        wait_drained();

        // min gains and trim, zero period freezes the integrator
        load_law(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0);
        push_word(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_word(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_word(32'h0001_0000, 32'hffff_0000, '0, '0);
        push_word('0, '0, '0, '0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            wild = (p % 3 == 1);
            load_law(rand_gain(wild), rand_gain(wild), rand_gain(wild), rand_gain(wild),
                     rand_gain(wild), rand_period());
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_WORDS; n++)
                push_word(rand_q(wild), rand_q(wild), rand_q(wild), rand_q(wild));
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
